### hw/rtl/heart_rate_measurement_parser_core_assert.svh
// Assertion macros for the heart rate measurement parser.
`ifndef HEART_RATE_MEASUREMENT_PARSER_CORE_ASSERT_SVH
`define HEART_RATE_MEASUREMENT_PARSER_CORE_ASSERT_SVH

// Checked only outside reset.
`define HRMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define HRMP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/hrmp_pkg.sv
package hrmp_pkg;

  localparam int unsigned MAX_INTERVALS_DEFAULT = 10;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned COUNT_W = 4;
  localparam int unsigned LEVEL_W = 3;

  // flag byte bit positions
  localparam int unsigned FLAG_HR16_BIT   = 0;
  localparam int unsigned FLAG_ENERGY_BIT = 3;
  localparam int unsigned FLAG_RRI_BIT    = 4;

  // result kinds
  localparam logic KIND_RR      = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [15:0]        rr_interval;
    logic [15:0]        heart_rate;
    logic [15:0]        energy_spent;
    logic [COUNT_W-1:0] interval_count;
    logic [LEVEL_W-1:0] signal_level;
    logic               malformed;
    logic               last;
  } result_t;

  // up to two results written per request, first one goes out first
  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

### hw/rtl/heart_rate_measurement_parser_core.sv
// Heart rate measurement packet parser.
// Slave side takes one packet byte per request: s_tdata[7:0] is the byte,
// s_tdata[15:8] the signal strength in dBm (read on the last byte only),
// s_tlast marks the final byte of a packet; the flags byte comes first.
// Master side gives results: m_tuser is the kind (0 = RR interval,
// 1 = packet summary), m_tlast is high on the summary.
// Throughput: one byte per cycle while the queue has room. A byte is held
// in the input register and, with room in the queue, its results enter
// the 4-entry result queue as it leaves that register; the first result
// is then offered to the master side. A byte that closes an RR interval
// on the last byte of a packet makes two results; these leave the queue
// one after the other. The input stage advances only while the queue
// holds room for two results.
// Reset clears the parse state (next byte is a flags byte) and empties the
// queue. When the receiver stalls, bytes that make no result keep flowing;
// once more than two results wait, the input register holds its byte and
// s_tready stays low until a result leaves the queue; nothing is lost.
`include "heart_rate_measurement_parser_core_assert.svh"

module heart_rate_measurement_parser_core #(
  parameter int unsigned MAX_INTERVALS = hrmp_pkg::MAX_INTERVALS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // packet_byte[7:0], signal_dbm[15:8]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // rr_interval[15:0], heart_rate[31:16],
                                 // energy_spent[47:32], interval_count[51:48],
                                 // signal_level[54:52], malformed[55]
  output logic        m_tuser,   // result_kind
  output logic        m_tlast
);

  hrmp_pkg::push_t                 push;
  hrmp_pkg::result_t               res;
  logic [hrmp_pkg::FIFO_LVL_W-1:0] fifo_level;

  hrmp_parser #(
    .MAX_INTERVALS(MAX_INTERVALS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata[7:0]),
    .in_last   (s_tlast),
    .in_dbm    (s_tdata[15:8]),
    .fifo_level(fifo_level),
    .push      (push)
  );

  hrmp_result_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .level    (fifo_level),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (res)
  );

  assign m_tdata = {res.malformed, res.signal_level, res.interval_count,
                    res.energy_spent, res.heart_rate, res.rr_interval};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

  `HRMP_ASSERT(a_queue_bound,
    fifo_level <= hrmp_pkg::FIFO_LVL_W'(hrmp_pkg::FIFO_DEPTH), "result queue overflow")
  `HRMP_ASSERT(a_rr_not_last,
    m_tvalid && (m_tuser == hrmp_pkg::KIND_RR) |-> !m_tlast, "RR interval marked last")
  `HRMP_ASSERT(a_count_cap,
    m_tvalid && (m_tuser == hrmp_pkg::KIND_SUMMARY) |-> (m_tdata[51:48] <= 4'(MAX_INTERVALS)),
    "interval count above cap")
  `HRMP_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid right after reset")

endmodule

### hw/rtl/hrmp_parser.sv
module hrmp_parser #(
  parameter int unsigned MAX_INTERVALS = hrmp_pkg::MAX_INTERVALS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_byte,
  input  logic                             in_last,
  input  logic signed [7:0]                in_dbm,
  input  logic [hrmp_pkg::FIFO_LVL_W-1:0]  fifo_level,
  output hrmp_pkg::push_t                  push
);

  typedef enum logic [2:0] {
    PH_FLAGS = 3'd0,
    PH_HR_LO = 3'd1,
    PH_HR_HI = 3'd2,
    PH_EN_LO = 3'd3,
    PH_EN_HI = 3'd4,
    PH_RR_LO = 3'd5,
    PH_RR_HI = 3'd6,
    PH_SKIP  = 3'd7
  } phase_t;

  localparam int unsigned CW = hrmp_pkg::COUNT_W;
  localparam logic [hrmp_pkg::FIFO_LVL_W-1:0] ROOM_MAX =
    hrmp_pkg::FIFO_LVL_W'(hrmp_pkg::FIFO_DEPTH - 2);

  // input register
  logic              stg_valid;
  logic [7:0]        stg_byte;
  logic              stg_last;
  logic signed [7:0] stg_dbm;

  // parse state
  phase_t        phase, phase_mid, phase_next;
  logic [7:0]    flags, flags_next;
  logic [15:0]   rate, rate_next;
  logic [15:0]   energy, energy_next;
  logic [7:0]    pend, pend_next;
  logic [CW-1:0] taken, taken_next;

  logic   advance;
  logic   rr_emit;
  logic   bad;
  phase_t after_rate;
  phase_t after_energy;
  logic [hrmp_pkg::LEVEL_W-1:0] level;
  hrmp_pkg::result_t rr_res, sum_res;

  // room for two results, whatever the receiver does this cycle
  assign advance  = stg_valid && (fifo_level <= ROOM_MAX);
  assign in_ready = !stg_valid || advance;

  always_comb begin
    if (flags[hrmp_pkg::FLAG_ENERGY_BIT]) begin
      after_rate = PH_EN_LO;
    end else if (flags[hrmp_pkg::FLAG_RRI_BIT]) begin
      after_rate = PH_RR_LO;
    end else begin
      after_rate = PH_SKIP;
    end
    after_energy = flags[hrmp_pkg::FLAG_RRI_BIT] ? PH_RR_LO : PH_SKIP;
  end

  always_comb begin
    phase_mid   = phase;
    flags_next  = flags;
    rate_next   = rate;
    energy_next = energy;
    pend_next   = pend;
    taken_next  = taken;
    rr_emit     = 1'b0;
    unique case (phase)
      PH_FLAGS: begin
        flags_next  = stg_byte;
        rate_next   = '0;
        energy_next = '0;
        pend_next   = '0;
        taken_next  = '0;
        phase_mid   = PH_HR_LO;
      end
      PH_HR_LO: begin
        rate_next = {8'h00, stg_byte};
        phase_mid = flags[hrmp_pkg::FLAG_HR16_BIT] ? PH_HR_HI : after_rate;
      end
      PH_HR_HI: begin
        rate_next = {stg_byte, rate[7:0]};
        phase_mid = after_rate;
      end
      PH_EN_LO: begin
        energy_next = {8'h00, stg_byte};
        phase_mid   = PH_EN_HI;
      end
      PH_EN_HI: begin
        energy_next = {stg_byte, energy[7:0]};
        phase_mid   = after_energy;
      end
      PH_RR_LO: begin
        pend_next = stg_byte;
        phase_mid = PH_RR_HI;
      end
      PH_RR_HI: begin
        if (taken < CW'(MAX_INTERVALS)) begin
          rr_emit    = 1'b1;
          taken_next = CW'(taken + CW'(1));
        end
        phase_mid = PH_RR_LO;
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase
    // cut short inside heart rate or energy
    bad = (phase_mid == PH_HR_LO) || (phase_mid == PH_HR_HI) ||
          (phase_mid == PH_EN_LO) || (phase_mid == PH_EN_HI);
    phase_next = stg_last ? PH_FLAGS : phase_mid;
  end

  // (dBm+100)/10 truncated, clamped to 0..4
  always_comb begin
    if (stg_dbm < -8'sd90) begin
      level = 3'd0;
    end else if (stg_dbm < -8'sd80) begin
      level = 3'd1;
    end else if (stg_dbm < -8'sd70) begin
      level = 3'd2;
    end else if (stg_dbm < -8'sd60) begin
      level = 3'd3;
    end else begin
      level = 3'd4;
    end
  end

  always_comb begin
    rr_res                = '0;
    rr_res.kind           = hrmp_pkg::KIND_RR;
    rr_res.rr_interval    = {stg_byte, pend};
    sum_res               = '0;
    sum_res.kind          = hrmp_pkg::KIND_SUMMARY;
    sum_res.heart_rate    = rate_next;
    sum_res.energy_spent  = energy_next;
    sum_res.interval_count = taken_next;
    sum_res.signal_level  = level;
    sum_res.malformed     = bad;
    sum_res.last          = 1'b1;

    push.n      = advance ? (2'(rr_emit) + 2'(stg_last)) : 2'd0;
    push.first  = rr_emit ? rr_res : sum_res;
    push.second = sum_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      phase     <= PH_FLAGS;
      flags     <= '0;
      rate      <= '0;
      energy    <= '0;
      pend      <= '0;
      taken     <= '0;
    end else begin
      if (in_valid && in_ready) begin
        stg_valid <= 1'b1;
      end else if (advance) begin
        stg_valid <= 1'b0;
      end
      if (advance) begin
        phase  <= phase_next;
        flags  <= flags_next;
        rate   <= rate_next;
        energy <= energy_next;
        pend   <= pend_next;
        taken  <= taken_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte <= in_byte;
      stg_last <= in_last;
      stg_dbm  <= in_dbm;
    end
  end

endmodule

### hw/rtl/hrmp_result_fifo.sv
module hrmp_result_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  hrmp_pkg::push_t                 push,
  output logic [hrmp_pkg::FIFO_LVL_W-1:0] level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output hrmp_pkg::result_t               out_data
);

  localparam int unsigned PW = hrmp_pkg::FIFO_PTR_W;
  localparam int unsigned LW = hrmp_pkg::FIFO_LVL_W;

  hrmp_pkg::result_t mem [hrmp_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW-1:0] wr_ptr1;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (level != '0);
  assign out_data  = mem[rd_ptr];
  assign wr_ptr1   = PW'(wr_ptr + PW'(1));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= PW'(wr_ptr + PW'(push.n));
      if (pop) begin
        rd_ptr <= PW'(rd_ptr + PW'(1));
      end
      level <= LW'(level + LW'(push.n) - LW'(pop));
    end
  end

endmodule
